[hdl/skt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the sorted key table.
// No dependencies; used by sorted_key_table.
package skt_pkg;

  // Command codes on the input word; the unused code acts as a search
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_FINISH
  } state_e;

endpackage

[hdl/sorted_key_table.sv]
`timescale 1ns / 1ps
// Top level of the sorted key table: control sequencer around the key store.
// Depends on skt_pkg and skt_ram.
//
// Holds up to CAPACITY unique signed keys in ascending order in a single-port
// read / single-port write memory, plus an entry count. Each input word is an
// insert, remove or search; each produces one output word with a status, a
// position and the entry count after the operation. Words are handled one at
// a time. A search is a linear scan that reads one entry per cycle through
// the memory read port. An insert at position p adds a shift pass that moves
// the larger keys up one slot and writes the new key; a remove at position s
// adds a pass that moves later keys down. The result word is held until the
// consumer takes it. An insert on a full table skips the scan and goes
// straight to its result. The memory needs no clearing after reset: only
// slots below the entry count are ever read.
module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [5:0]         position_o,
  output logic [6:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  skt_pkg::state_e  state_q, state_d;
  skt_pkg::status_e status_q, status_d;
  logic [1:0]         cmd_q, cmd_d;
  logic signed [31:0] key_q, key_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [CW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]      lt_q, lt_d;
  logic [CW-1:0]      slot_q, slot_d;
  logic               pvld_q, pvld_d;
  logic [CW-1:0]      pidx_q, pidx_d;

  logic               out_valid_q, out_valid_d;
  skt_pkg::status_e   out_status_q, out_status_d;
  logic [5:0]         out_pos_q, out_pos_d;
  logic [6:0]         out_cnt_q, out_cnt_d;

  logic               rd_en, wr_en, ld_out, hit;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data, rd_data;
  logic [CW-1:0]      rd_prev;
  logic [CW+5:0]      slot_ext;
  logic [CW+6:0]      fill_ext;
  logic               is_insert, is_remove;

  skt_ram #(
    .Depth (CAPACITY),
    .AddrW (AW),
    .DataW (skt_pkg::KEY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_prev   = rd_ptr_q - CW'(1);
  assign is_insert = (cmd_q == skt_pkg::CMD_INSERT);
  assign is_remove = (cmd_q == skt_pkg::CMD_REMOVE);
  assign hit       = pvld_q && (rd_data == key_q);
  assign slot_ext  = {6'b0, slot_q};
  assign fill_ext  = {7'b0, fill_d};

  // Sequence scan, shift, place and result load
  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    fill_d       = fill_q;
    rd_ptr_d     = rd_ptr_q;
    lt_d         = lt_q;
    slot_d       = slot_q;
    pvld_d       = 1'b0;
    pidx_d       = pidx_q;
    rd_en        = 1'b0;
    rd_addr      = rd_ptr_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = pidx_q[AW-1:0];
    wr_data      = rd_data;
    ld_out       = 1'b0;
    in_ready_o   = 1'b0;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_cnt_d    = out_cnt_q;

    case (state_q)
      skt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          key_d    = key_i;
          rd_ptr_d = '0;
          lt_d     = '0;
          slot_d   = '0;
          if (cmd_i == skt_pkg::CMD_INSERT && fill_q == CW'(CAPACITY)) begin
            status_d = skt_pkg::ST_FULL;
            state_d  = skt_pkg::S_FINISH;
          end else begin
            state_d = skt_pkg::S_SCAN;
          end
        end
      end

      skt_pkg::S_SCAN: begin
        if (hit) begin
          // Key present: duplicate on insert, otherwise report its slot
          if (is_insert) begin
            status_d = skt_pkg::ST_DUP;
            state_d  = skt_pkg::S_FINISH;
          end else begin
            status_d = skt_pkg::ST_OK;
            slot_d   = pidx_q;
            if (is_remove) begin
              rd_ptr_d = pidx_q + CW'(1);
              state_d  = skt_pkg::S_SHIFT;
            end else begin
              state_d = skt_pkg::S_FINISH;
            end
          end
        end else if (!pvld_q && rd_ptr_q >= fill_q) begin
          // Scan done without a match
          if (is_insert) begin
            status_d = skt_pkg::ST_OK;
            slot_d   = lt_q;
            rd_ptr_d = fill_q;
            state_d  = skt_pkg::S_SHIFT;
          end else begin
            status_d = skt_pkg::ST_MISSING;
            state_d  = skt_pkg::S_FINISH;
          end
        end else begin
          // Count smaller keys, issue the next read
          if (pvld_q && $signed(rd_data) < key_q) begin
            lt_d = lt_q + CW'(1);
          end
          if (rd_ptr_q < fill_q) begin
            rd_en    = 1'b1;
            rd_addr  = rd_ptr_q[AW-1:0];
            pvld_d   = 1'b1;
            pidx_d   = rd_ptr_q;
            rd_ptr_d = rd_ptr_q + CW'(1);
          end
        end
      end

      skt_pkg::S_SHIFT: begin
        // Write back the word read last cycle
        if (pvld_q) begin
          wr_en   = 1'b1;
          wr_addr = pidx_q[AW-1:0];
          wr_data = rd_data;
        end
        if (is_insert) begin
          // Move keys up from the top down to the insert slot
          if (rd_ptr_q > slot_q) begin
            rd_en    = 1'b1;
            rd_addr  = rd_prev[AW-1:0];
            pvld_d   = 1'b1;
            pidx_d   = rd_ptr_q;
            rd_ptr_d = rd_prev;
          end else if (!pvld_q) begin
            state_d = skt_pkg::S_PLACE;
          end
        end else begin
          // Move later keys down over the removed slot
          if (rd_ptr_q < fill_q) begin
            rd_en    = 1'b1;
            rd_addr  = rd_ptr_q[AW-1:0];
            pvld_d   = 1'b1;
            pidx_d   = rd_prev;
            rd_ptr_d = rd_ptr_q + CW'(1);
          end else if (!pvld_q) begin
            state_d = skt_pkg::S_FINISH;
          end
        end
      end

      skt_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = slot_q[AW-1:0];
        wr_data = key_q;
        state_d = skt_pkg::S_FINISH;
      end

      skt_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ld_out = 1'b1;
          if (status_q == skt_pkg::ST_OK && is_insert) begin
            fill_d = fill_q + CW'(1);
          end else if (status_q == skt_pkg::ST_OK && is_remove) begin
            fill_d = fill_q - CW'(1);
          end
          out_status_d = status_q;
          out_pos_d    = slot_ext[5:0];
          out_cnt_d    = fill_ext[6:0];
          state_d      = skt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the output word until taken
  always_comb begin
    if (ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::S_IDLE;
      fill_q      <= '0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pvld_q      <= pvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    rd_ptr_q     <= rd_ptr_d;
    lt_q         <= lt_d;
    slot_q       <= slot_d;
    pidx_q       <= pidx_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_cnt_q;

  // Entry count never exceeds the table size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Memory is written only while shifting or placing a key
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == skt_pkg::S_SHIFT || state_q == skt_pkg::S_PLACE))
    else $error("key store written outside shift or place");

  // Entry count changes only together with a result load
  a_fill_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fill_q) |-> $past(ld_out))
    else $error("entry count changed without a result");

  // An accepted word starts a scan or goes straight to its result
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=>
      (state_q == skt_pkg::S_SCAN || state_q == skt_pkg::S_FINISH))
    else $error("accepted word did not start processing");

endmodule

[hdl/skt_ram.sv]
`timescale 1ns / 1ps
// Key store of the sorted key table: one write port, one read port,
// read data registered. No package dependencies.
module skt_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // Write the word at the write address
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
